[rtl/pbfs_pkg.sv]
// ----------------------------------------------------------------------------
// pbfs_pkg
// Shared constants, types and helper functions for the packed bit field store.
// ----------------------------------------------------------------------------
package pbfs_pkg;

  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = 1024;
  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam int ADDR_W     = $clog2(NUM_WORDS);
  localparam int BANK_DEPTH = (NUM_WORDS + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int START_W    = 16;
  localparam int LEN_W      = 7;
  localparam int IDX_W      = START_W - OFF_W;

  // Access codes carried by the mode field.
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Decoded access, held while the word pair is read and rewritten.
  typedef struct packed {
    logic             mode;
    logic             rev;
    logic             err;
    logic             straddle;
    logic             low_odd;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } pbfs_op_t;

  // Full reversal of a word; independent bits only.
  function automatic logic [WORD_BITS-1:0] rev_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] r;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[i] = v[WORD_BITS-1-i];
    end
    return r;
  endfunction

  // Mask of the low len bits, all ones for a full word.
  function automatic logic [WORD_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [WORD_BITS-1:0] m;
    if (32'(len) >= WORD_BITS) begin
      m = '1;
    end else begin
      m = ({{(WORD_BITS-1){1'b0}}, 1'b1} << len) - {{(WORD_BITS-1){1'b0}}, 1'b1};
    end
    return m;
  endfunction

endpackage

[rtl/pbfs_bank.sv]
// ----------------------------------------------------------------------------
// pbfs_bank
// One bank of store words: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pbfs_bank (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [pbfs_pkg::BANK_AW-1:0]         rd_addr,
  output logic [pbfs_pkg::WORD_BITS-1:0]       rd_data,
  input  logic                                 wr_en,
  input  logic [pbfs_pkg::BANK_AW-1:0]         wr_addr,
  input  logic [pbfs_pkg::WORD_BITS-1:0]       wr_data
);

  logic [pbfs_pkg::WORD_BITS-1:0] mem [pbfs_pkg::BANK_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/pbfs_field.sv]
// ----------------------------------------------------------------------------
// pbfs_field
// Field extract and insert over the pair of words read from the two banks.
// ----------------------------------------------------------------------------
module pbfs_field (
  input  pbfs_pkg::pbfs_op_t                   op,
  input  logic [pbfs_pkg::WORD_BITS-1:0]       write_value,
  input  logic [pbfs_pkg::WORD_BITS-1:0]       even_rdata,
  input  logic [pbfs_pkg::WORD_BITS-1:0]       odd_rdata,
  output logic [pbfs_pkg::WORD_BITS-1:0]       read_value,
  output logic [pbfs_pkg::WORD_BITS-1:0]       even_wdata,
  output logic [pbfs_pkg::WORD_BITS-1:0]       odd_wdata,
  output logic                                 even_we,
  output logic                                 odd_we
);

  localparam int W = pbfs_pkg::WORD_BITS;

  logic [W-1:0]   lo_word;
  logic [W-1:0]   hi_word;
  logic [2*W-1:0] pair;
  logic [2*W-1:0] pair_shr;
  logic [2*W-1:0] pair_new;
  logic [2*W-1:0] mask_shl;
  logic [2*W-1:0] val_shl;
  logic [W-1:0]   mask;
  logic [W-1:0]   raw;
  logic [W-1:0]   wval;
  logic [W-1:0]   rshift;
  logic           is_write;

  // The lower word of the field sits in the odd bank when the first word index is odd.
  assign lo_word = op.low_odd ? odd_rdata : even_rdata;
  assign hi_word = op.low_odd ? even_rdata : odd_rdata;
  assign pair    = {hi_word, lo_word};
  assign mask    = pbfs_pkg::len_mask(op.len);
  assign rshift  = W'(W) - W'(op.len);

  // Read path: shift the pair down, mask, optionally reverse within the field.
  assign pair_shr = pair >> op.off;
  assign raw      = pair_shr[W-1:0] & mask;

  always_comb begin
    if (op.err || op.mode == pbfs_pkg::MODE_WRITE) begin
      read_value = '0;
    end else if (op.rev) begin
      read_value = pbfs_pkg::rev_word(raw) >> rshift;
    end else begin
      read_value = raw;
    end
  end

  // Write path: mask the value, optionally reverse, then merge into the pair.
  always_comb begin
    if (op.rev) begin
      wval = pbfs_pkg::rev_word(write_value & mask) >> rshift;
    end else begin
      wval = write_value & mask;
    end
  end

  assign mask_shl = {{W{1'b0}}, mask} << op.off;
  assign val_shl  = {{W{1'b0}}, wval} << op.off;
  assign pair_new = (pair & ~mask_shl) | val_shl;

  // Route the merged words back to their banks.
  assign is_write   = (op.mode == pbfs_pkg::MODE_WRITE) && !op.err;
  assign even_wdata = op.low_odd ? pair_new[2*W-1:W] : pair_new[W-1:0];
  assign odd_wdata  = op.low_odd ? pair_new[W-1:0] : pair_new[2*W-1:W];
  assign even_we    = is_write && (!op.low_odd || op.straddle);
  assign odd_we     = is_write && (op.low_odd || op.straddle);

endmodule

[rtl/packed_bit_field_store.sv]
// ----------------------------------------------------------------------------
// packed_bit_field_store
// Packed bit array in 64-bit words held in even and odd banks; reads or
// writes a field of 1 to 64 bits that may straddle two adjacent words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports
//  in        input      in_valid, in_ready, in_mode, in_start_bit, in_field_length,
//                       in_write_value, in_reverse_bits
//  out       output     out_valid, out_ready, out_read_value, out_range_error
//
//  One word is in flight at a time: the bank read is issued as it is accepted,
//  and the merge and write-back follow from the registered bank data once the
//  output register is free. After reset a clearing pass zeroes all BANK_DEPTH
//  (512) rows of both banks, one row a cycle, before the first word is taken.
//  A result waiting at the output holds the next word in the write-back stage,
//  and the input is refused until that word has been written back.
// ----------------------------------------------------------------------------
module packed_bit_field_store (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [pbfs_pkg::START_W-1:0]         in_start_bit,
  input  logic [pbfs_pkg::LEN_W-1:0]           in_field_length,
  input  logic [pbfs_pkg::WORD_BITS-1:0]       in_write_value,
  input  logic                                 in_reverse_bits,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pbfs_pkg::WORD_BITS-1:0]       out_read_value,
  output logic                                 out_range_error
);

  localparam int W = pbfs_pkg::WORD_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WORK  = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pbfs_pkg::BANK_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  pbfs_pkg::pbfs_op_t              op_r, op_nxt;
  logic [W-1:0]                    wval_r;
  logic [pbfs_pkg::BANK_AW-1:0]    even_addr_r, odd_addr_r;
  logic [pbfs_pkg::BANK_AW-1:0]    even_addr_nxt, odd_addr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [W-1:0]                    out_value_r;
  logic                            out_err_r;

  logic                            accept;
  logic                            done;
  logic                            clr_last;
  logic [pbfs_pkg::IDX_W-1:0]      w0;
  logic [pbfs_pkg::ADDR_W-1:0]     w0_addr;
  logic [pbfs_pkg::START_W:0]      end_bit;
  logic [pbfs_pkg::OFF_W+1:0]      off_len;

  logic [W-1:0]                    even_rdata, odd_rdata;
  logic [W-1:0]                    even_wdata, odd_wdata;
  logic                            even_we, odd_we;
  logic [W-1:0]                    field_value;
  logic                            bank_even_we, bank_odd_we;
  logic [pbfs_pkg::BANK_AW-1:0]    bank_even_waddr, bank_odd_waddr;
  logic [W-1:0]                    bank_even_wdata, bank_odd_wdata;

  // Handshake.
  assign in_ready        = (state_r == ST_IDLE);
  assign accept          = in_valid && in_ready;
  assign done            = (state_r == ST_WORK) && (!out_valid_r || out_ready);
  assign clr_last        = (32'(clr_cnt_r) == pbfs_pkg::BANK_DEPTH - 1);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_range_error = out_err_r;

  // Decode of the incoming word: range check, offset and bank addresses.
  assign w0      = in_start_bit[pbfs_pkg::START_W-1:pbfs_pkg::OFF_W];
  assign w0_addr = pbfs_pkg::ADDR_W'(w0);
  assign end_bit = {1'b0, in_start_bit} + (pbfs_pkg::START_W+1)'(in_field_length);
  assign off_len = (pbfs_pkg::OFF_W+2)'(in_start_bit[pbfs_pkg::OFF_W-1:0])
                 + (pbfs_pkg::OFF_W+2)'(in_field_length);

  always_comb begin
    op_nxt.mode     = in_mode;
    op_nxt.rev      = in_reverse_bits;
    op_nxt.err      = (in_field_length == '0) || (32'(in_field_length) > W)
                   || (32'(end_bit) > pbfs_pkg::TOTAL_BITS);
    op_nxt.straddle = (32'(off_len) > W);
    op_nxt.low_odd  = w0_addr[0];
    op_nxt.off      = in_start_bit[pbfs_pkg::OFF_W-1:0];
    op_nxt.len      = in_field_length;
    // The odd bank row is the first index halved; the even row rounds it up.
    odd_addr_nxt    = pbfs_pkg::BANK_AW'(w0_addr >> 1);
    even_addr_nxt   = pbfs_pkg::BANK_AW'((w0_addr >> 1) + pbfs_pkg::ADDR_W'(w0_addr[0]));
  end

  // Sequencer: clearing pass, idle, then merge and write back.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers for the word in flight and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= op_nxt;
      wval_r      <= in_write_value;
      even_addr_r <= even_addr_nxt;
      odd_addr_r  <= odd_addr_nxt;
    end
    if (done) begin
      out_value_r <= field_value;
      out_err_r   <= op_r.err;
    end
  end

  // Bank write ports: zeroes during the clearing pass, merged words otherwise.
  assign bank_even_we    = (state_r == ST_CLEAR) || (done && even_we);
  assign bank_odd_we     = (state_r == ST_CLEAR) || (done && odd_we);
  assign bank_even_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : even_addr_r;
  assign bank_odd_waddr  = (state_r == ST_CLEAR) ? clr_cnt_r : odd_addr_r;
  assign bank_even_wdata = (state_r == ST_CLEAR) ? '0 : even_wdata;
  assign bank_odd_wdata  = (state_r == ST_CLEAR) ? '0 : odd_wdata;

  pbfs_bank u_even (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (even_addr_nxt),
    .rd_data (even_rdata),
    .wr_en   (bank_even_we),
    .wr_addr (bank_even_waddr),
    .wr_data (bank_even_wdata)
  );

  pbfs_bank u_odd (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (odd_addr_nxt),
    .rd_data (odd_rdata),
    .wr_en   (bank_odd_we),
    .wr_addr (bank_odd_waddr),
    .wr_data (bank_odd_wdata)
  );

  pbfs_field u_field (
    .op          (op_r),
    .write_value (wval_r),
    .even_rdata  (even_rdata),
    .odd_rdata   (odd_rdata),
    .read_value  (field_value),
    .even_wdata  (even_wdata),
    .odd_wdata   (odd_wdata),
    .even_we     (even_we),
    .odd_we      (odd_we)
  );

endmodule
